### sv/mkbm_pkg.sv
// Shared types and constants of the multi-keyword byte matcher.
// Holds the item structs, the mode codes and the parameter defaults.
// No dependencies.
package mkbm_pkg;

    // Parameter defaults
    localparam int NUM_KEYWORDS_DEF = 16;
    localparam int MAX_KEY_LEN_DEF  = 32;

    // Item mode codes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_SCAN    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] key_slot;
        logic [4:0] key_pos;
        logic [5:0] key_length;
        logic [7:0] data_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [63:0] hit_address;
        logic [3:0]  hit_slot;
        logic [5:0]  hit_length;
        logic        last_hit;
    } t_out_item;

    // Control handed to every window cell
    typedef struct packed {
        logic       shift;
        logic       load;
        logic [3:0] key_slot;
        logic [4:0] key_pos;
        logic [7:0] data_byte;
    } t_cell_ctl;

endpackage

### sv/mkbm_cell.sv
// One window cell: holds one window byte and the keyword bytes at its position.
// Passes its byte to the next older cell on every scan and flags equal keywords.
// Depends on mkbm_pkg.
module mkbm_cell #(
    parameter int NUM_KEYWORDS = mkbm_pkg::NUM_KEYWORDS_DEF,
    parameter int POS          = 0
) (
    input  logic                    i_clk,
    input  mkbm_pkg::t_cell_ctl     i_ctl,
    input  logic [7:0]              i_byte,
    output logic [7:0]              o_byte,
    output logic [NUM_KEYWORDS-1:0] o_eq
);

    logic [7:0] r_win;
    logic [7:0] r_key [NUM_KEYWORDS];

    // Shift the window byte in from the younger neighbour
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= i_byte;
        end
    end

    // Store keyword bytes addressed to this position
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            if (i_ctl.load && 32'(i_ctl.key_pos) == POS && 32'(i_ctl.key_slot) == s) begin
                r_key[s] <= i_ctl.data_byte;
            end
        end
    end

    // Compare every keyword byte with the window byte
    always_comb begin
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            o_eq[s] = (r_key[s] == r_win);
        end
    end

    assign o_byte = r_win;

endmodule

### sv/mkbm_hit_seq.sv
// Hit sequencer: takes the match vector of one start position and emits one hit per
// cycle unless the output stalls, shortest keyword first, then lowest slot, through an
// output register. Depends on mkbm_pkg.
module mkbm_hit_seq #(
    parameter int NUM_KEYWORDS = mkbm_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_KEY_LEN  = mkbm_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [NUM_KEYWORDS-1:0]   i_match,
    input  logic [63:0]               i_address,
    input  logic [$clog2(MAX_KEY_LEN+1)-1:0] i_len [NUM_KEYWORDS],
    output logic                      o_busy,
    output logic                      o_valid,
    input  logic                      i_stall,
    output mkbm_pkg::t_out_item       o_item
);

    localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int SLOT_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    logic [NUM_KEYWORDS-1:0] r_rem;
    logic [63:0]             r_address;
    logic                    r_out_valid;
    mkbm_pkg::t_out_item     r_out;

    logic [MAX_KEY_LEN:0]    w_map;
    logic [LEN_W-1:0]        w_cur;
    logic [SLOT_W-1:0]       w_sel;
    logic [NUM_KEYWORDS-1:0] w_sel_mask;
    logic                    w_adv;

    // Mark the lengths that still have hits pending
    always_comb begin
        w_map = '0;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            if (r_rem[s]) begin
                w_map[i_len[s]] = 1'b1;
            end
        end
    end

    // Pick the shortest pending length
    always_comb begin
        w_cur = '0;
        for (int l = MAX_KEY_LEN; l >= 0; l--) begin
            if (w_map[l]) begin
                w_cur = LEN_W'(l);
            end
        end
    end

    // Pick the lowest pending slot of that length
    always_comb begin
        w_sel      = '0;
        w_sel_mask = '0;
        for (int s = NUM_KEYWORDS - 1; s >= 0; s--) begin
            if (r_rem[s] && i_len[s] == w_cur) begin
                w_sel = SLOT_W'(s);
            end
        end
        w_sel_mask[w_sel] = 1'b1;
    end

    assign w_adv = (|r_rem) && (!r_out_valid || !i_stall);

    // Advance the sequence and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_rem <= i_match;
            end else if (w_adv) begin
                r_rem <= r_rem & ~w_sel_mask;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload and hit address
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_address <= i_address;
        end
        if (w_adv) begin
            r_out.hit_address <= r_address;
            r_out.hit_slot    <= 4'(w_sel);
            r_out.hit_length  <= 6'(i_len[w_sel]);
            r_out.last_hit    <= ((r_rem & ~w_sel_mask) == '0);
        end
    end

    assign o_busy  = |r_rem;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

### sv/multi_keyword_byte_matcher.sv
// Multi-keyword byte matcher: exact search of up to NUM_KEYWORDS keywords in a byte stream.
// Load, length and restart items, and scans that leave the window short, add no input stall of their own.
// A scan with a full window stalls the input for a registered parallel compare across the
// cell row, then while the sequencer emits one hit per cycle unless the output stalls.
// Synchronous active-low reset clears lengths, fill, offset and start address; keyword bytes
// hold no reset value until written.
module multi_keyword_byte_matcher #(
    parameter int NUM_KEYWORDS = mkbm_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_KEY_LEN  = mkbm_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mkbm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mkbm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [63:0]         i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);

    logic [63:0]      r_start;
    logic [63:0]      r_offset;
    logic [LEN_W-1:0] r_fill;
    logic             r_test;
    logic [LEN_W-1:0] r_len [NUM_KEYWORDS];

    logic                    w_acc;
    logic                    w_busy;
    mkbm_pkg::t_cell_ctl     w_ctl;
    logic [7:0]              w_byte [MAX_KEY_LEN+1];
    logic [NUM_KEYWORDS-1:0] w_eq [MAX_KEY_LEN];
    logic [NUM_KEYWORDS-1:0] w_match;
    logic [LEN_W-1:0]        w_new_len;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_test || w_busy;
    assign o_cfg_ready = 1'b1;

    // Cell control for this item
    always_comb begin
        w_ctl.shift     = w_acc && i_in_item.mode == mkbm_pkg::MODE_SCAN;
        w_ctl.load      = w_acc && i_in_item.mode == mkbm_pkg::MODE_LOAD;
        w_ctl.key_slot  = i_in_item.key_slot;
        w_ctl.key_pos   = i_in_item.key_pos;
        w_ctl.data_byte = i_in_item.data_byte;
    end

    // Row of window cells, newest byte enters at the top
    assign w_byte[MAX_KEY_LEN] = i_in_item.data_byte;

    for (genvar j = 0; j < MAX_KEY_LEN; j++) begin : g_cell
        mkbm_cell #(
            .NUM_KEYWORDS(NUM_KEYWORDS),
            .POS         (j)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_byte(w_byte[j+1]),
            .o_byte(w_byte[j]),
            .o_eq  (w_eq[j])
        );
    end

    // Combine cell flags over each keyword's length
    always_comb begin
        logic [MAX_KEY_LEN-1:0] v;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            for (int j = 0; j < MAX_KEY_LEN; j++) begin
                v[j] = w_eq[j][s] || (32'(r_len[s]) <= j);
            end
            w_match[s] = (r_len[s] != '0) && (&v);
        end
    end

    // Saturate a written length to the window size
    assign w_new_len = (32'(i_in_item.key_length) > MAX_KEY_LEN)
                     ? LEN_W'(MAX_KEY_LEN) : LEN_W'(i_in_item.key_length);

    // Hold lengths, fill, offset and start address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_offset <= '0;
            r_fill   <= '0;
            r_test   <= 1'b0;
            for (int s = 0; s < NUM_KEYWORDS; s++) begin
                r_len[s] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            r_test <= w_ctl.shift && (r_fill >= LEN_W'(MAX_KEY_LEN - 1));
            if (r_test) begin
                r_offset <= r_offset + 64'd1;
            end
            if (w_acc && i_in_item.mode == mkbm_pkg::MODE_RESTART) begin
                r_fill   <= '0;
                r_offset <= '0;
            end
            if (w_ctl.shift && r_fill != LEN_W'(MAX_KEY_LEN)) begin
                r_fill <= r_fill + LEN_W'(1);
            end
            for (int s = 0; s < NUM_KEYWORDS; s++) begin
                if (w_acc && i_in_item.mode == mkbm_pkg::MODE_LENGTH
                        && 32'(i_in_item.key_slot) == s) begin
                    r_len[s] <= w_new_len;
                end
            end
        end
    end

    // Emit hits in order
    mkbm_hit_seq #(
        .NUM_KEYWORDS(NUM_KEYWORDS),
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_hit_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_test),
        .i_match  (w_match),
        .i_address(r_start + r_offset),
        .i_len    (r_len),
        .o_busy   (w_busy),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item)
    );

endmodule

### dv/mkbm_hit_tracker.sv
`timescale 1ns / 100ps
// Hit tracker for the multi-keyword byte matcher: watches the item, hit and register channels,
// predicts every hit and compares the hits that arrive. Depends on mkbm_pkg.
module mkbm_hit_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mkbm_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mkbm_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [63:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_hits_seen
);

    localparam int KEYS = mkbm_pkg::NUM_KEYWORDS_DEF;
    localparam int KLEN = mkbm_pkg::MAX_KEY_LEN_DEF;

    // Own copy of the matcher state
    logic [7:0]  key_bytes [KEYS][KLEN];
    int          key_len [KEYS];
    logic [7:0]  window [KLEN];
    int          fill;
    logic [63:0] offset;
    logic [63:0] base_addr;

    // Hits predicted but not yet seen, oldest first
    mkbm_pkg::t_out_item due_hits[$];
    int                  fails;
    int                  hits;

    initial begin
        fails       = 0;
        hits        = 0;
        fill        = 0;
        offset      = '0;
        base_addr   = '0;
        o_fail_count = 0;
        o_pending    = 0;
        o_hits_seen  = 0;
        foreach (key_len[s]) key_len[s] = 0;
        foreach (window[i]) window[i] = '0;
        foreach (key_bytes[s, p]) key_bytes[s][p] = '0;
    end

    // Work out the hits that one accepted item causes and queue them
    task automatic apply_item(input mkbm_pkg::t_in_item it);
        mkbm_pkg::t_out_item batch[$];
        mkbm_pkg::t_out_item h;
        bit                  same;
        case (it.mode)
            mkbm_pkg::MODE_LOAD: begin
                if (int'(it.key_slot) < KEYS && int'(it.key_pos) < KLEN)
                    key_bytes[it.key_slot][it.key_pos] = it.data_byte;
            end
            mkbm_pkg::MODE_LENGTH: begin
                if (int'(it.key_slot) < KEYS)
                    key_len[it.key_slot] = (int'(it.key_length) > KLEN) ? KLEN
                                                                        : int'(it.key_length);
            end
            mkbm_pkg::MODE_RESTART: begin
                foreach (window[i]) window[i] = '0;
                fill   = 0;
                offset = '0;
            end
            default: begin
                // Shift the byte into the window
                if (fill < KLEN) begin
                    window[fill] = it.data_byte;
                    fill++;
                end else begin
                    for (int i = 0; i < KLEN - 1; i++) window[i] = window[i + 1];
                    window[KLEN - 1] = it.data_byte;
                end
                // Test the oldest position against every active keyword once the window is full
                if (fill == KLEN) begin
                    for (int len = 1; len <= KLEN; len++) begin
                        for (int s = 0; s < KEYS; s++) begin
                            if (key_len[s] == len) begin
                                same = 1'b1;
                                for (int i = 0; i < len; i++)
                                    if (key_bytes[s][i] != window[i]) same = 1'b0;
                                if (same) begin
                                    h.hit_address = base_addr + offset;
                                    h.hit_slot    = 4'(s);
                                    h.hit_length  = 6'(len);
                                    h.last_hit    = 1'b0;
                                    batch.push_back(h);
                                end
                            end
                        end
                    end
                    if (batch.size() > 0) batch[batch.size() - 1].last_hit = 1'b1;
                    foreach (batch[i]) due_hits.push_back(batch[i]);
                    offset = offset + 64'd1;
                end
            end
        endcase
    endtask

    task automatic report_field(input string fname, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: hit %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
        fails++;
    endtask

    // Compare one arriving hit with the oldest prediction
    task automatic check_hit(input mkbm_pkg::t_out_item got);
        mkbm_pkg::t_out_item want;
        hits++;
        if (due_hits.size() == 0) begin
            $display("%0t: unexpected hit, expected none, actual addr 0x%0h slot %0d len %0d",
                     $time, got.hit_address, got.hit_slot, got.hit_length);
            fails++;
        end else begin
            want = due_hits.pop_front();
            if (got.hit_address !== want.hit_address)
                report_field("address", want.hit_address, got.hit_address);
            if (got.hit_slot !== want.hit_slot)
                report_field("slot", 64'(want.hit_slot), 64'(got.hit_slot));
            if (got.hit_length !== want.hit_length)
                report_field("length", 64'(want.hit_length), 64'(got.hit_length));
            if (got.last_hit !== want.last_hit)
                report_field("last mark", 64'(want.last_hit), 64'(got.last_hit));
        end
    endtask

    // Sample all channels at the clock edge; hits before items so a fresh item never pairs
    // with an older hit
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (key_len[s]) key_len[s] = 0;
            foreach (window[i]) window[i] = '0;
            fill      = 0;
            offset    = '0;
            base_addr = '0;
            due_hits.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_hit(i_out_item);
            if (i_cfg_valid && i_cfg_ready) base_addr = i_cfg_data;
            if (i_in_valid && !i_in_stall) apply_item(i_in_item);
        end
        o_pending    <= due_hits.size();
        o_fail_count <= fails;
        o_hits_seen  <= hits;
    end

endmodule

### dv/tb_multi_keyword_byte_matcher.sv
`timescale 1ns / 100ps
// Top of the multi-keyword byte matcher testbench: clock, reset, stimulus and verdict.
// Depends on mkbm_pkg, multi_keyword_byte_matcher and mkbm_hit_tracker.
module tb_multi_keyword_byte_matcher;

    localparam int KEYS          = mkbm_pkg::NUM_KEYWORDS_DEF;
    localparam int KLEN          = mkbm_pkg::MAX_KEY_LEN_DEF;
    localparam int IDLE_PCT      = 27;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 24;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 300000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    mkbm_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mkbm_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [63:0]         i_cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          hits_seen;

    bit          idle_on     = 1'b1;
    int          item_count  = 0;
    int          cycle_count = 0;
    int          settings    = 0;

    // Stimulus view of the keyword slots, used to plant keywords and to keep reads defined
    logic [7:0]  shadow_bytes [KEYS][KLEN];
    bit          shadow_written [KEYS][KLEN];
    int          shadow_len [KEYS];
    logic [7:0]  alphabet [4] = '{8'h00, 8'h41, 8'h42, 8'hFF};
    logic [63:0] phase_base [PHASES];

    multi_keyword_byte_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    mkbm_hit_tracker u_hit_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hits_seen  (hits_seen)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the hit channel at random while idling is on
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d hits outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random item with every field filled, so unused fields see both bit values
    function automatic mkbm_pkg::t_in_item noise_item();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(mkbm_pkg::t_in_item)-1:0];
    endfunction

    // Mostly a small alphabet so that short keywords turn up by chance
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(9) < 7) return alphabet[$urandom_range(3)];
        return 8'($urandom);
    endfunction

    // Offer one item, holding it until accepted
    task automatic send_item(input mkbm_pkg::t_in_item it);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        item_count++;
    endtask

    task automatic load_byte(input int s, input int p, input logic [7:0] b);
        mkbm_pkg::t_in_item it;
        it          = noise_item();
        it.mode     = mkbm_pkg::MODE_LOAD;
        it.key_slot = 4'(s);
        it.key_pos  = 5'(p);
        it.data_byte = b;
        shadow_bytes[s][p]   = b;
        shadow_written[s][p] = 1'b1;
        send_item(it);
    endtask

    task automatic set_length(input int s, input int lenf);
        mkbm_pkg::t_in_item it;
        it            = noise_item();
        it.mode       = mkbm_pkg::MODE_LENGTH;
        it.key_slot   = 4'(s);
        it.key_length = 6'(lenf);
        shadow_len[s] = (lenf > KLEN) ? KLEN : lenf;
        send_item(it);
    endtask

    task automatic scan_byte(input logic [7:0] b);
        mkbm_pkg::t_in_item it;
        it           = noise_item();
        it.mode      = mkbm_pkg::MODE_SCAN;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic restart_stream();
        mkbm_pkg::t_in_item it;
        it      = noise_item();
        it.mode = mkbm_pkg::MODE_RESTART;
        send_item(it);
    endtask

    // Load a whole keyword from position 0, then enable it
    task automatic define_keyword(input int s, input int n, input int lenf,
                                  input logic [7:0] b, input bit mixed);
        for (int p = 0; p < n; p++) load_byte(s, p, mixed ? pick_byte() : b);
        set_length(s, lenf);
    endtask

    // Drop valid and wait until every predicted hit has come
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        int  s;
        int  n;
        int  lenf;
        int  eff;
        int  act;
        int  phase_count;
        bit  ok;

        foreach (shadow_len[k]) shadow_len[k] = 0;
        foreach (shadow_written[k, p]) begin
            shadow_written[k][p] = 1'b0;
            shadow_bytes[k][p]   = '0;
        end
        phase_base[0] = 64'h0;
        phase_base[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_base[2] = {$urandom, $urandom};
        phase_base[3] = 64'h8000_0000_0000_0000;
        phase_base[4] = 64'hFFFF_FFFF_FFFF_FFE0;

        // Hold reset at the start, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: start near the top so addresses wrap
        write_start(64'hFFFF_FFFF_FFFF_FFF0);
        define_keyword(0, 1, 1, 8'h00, 1'b0);
        define_keyword(15, 1, 1, 8'h00, 1'b0);
        load_byte(3, 0, 8'h00);
        load_byte(3, 1, 8'hFF);
        set_length(3, 2);
        // Enable then disable a slot
        define_keyword(9, 1, 1, 8'hFF, 1'b0);
        set_length(9, 0);
        // Full-width keyword with an overlong length
        define_keyword(5, KLEN, 63, 8'h00, 1'b0);
        // Window still filling, then full windows of zero and a mixed run
        repeat (KLEN - 1) scan_byte(8'h00);
        repeat (8) scan_byte(8'h00);
        for (int i = 0; i < 20; i++) scan_byte(i[0] ? 8'hFF : 8'h00);
        // Stream tail left untested, then a short stream that never fills
        restart_stream();
        repeat (5) scan_byte(8'h00);
        restart_stream();

        // Random phases, each under its own start address
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_start(phase_base[ph]);
            idle_on = (ph != 1);
            restart_stream();
            // Flood: every slot matches the same position
            if (ph == 2) begin
                for (int k = 0; k < KEYS; k++)
                    define_keyword(k, 1 + k % 3, 1 + k % 3, 8'h41, 1'b0);
                restart_stream();
                repeat (KLEN + 4) scan_byte(8'h41);
            end
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                act = $urandom_range(99);
                s   = $urandom_range(KEYS - 1);
                if (act < 12) begin
                    n    = ($urandom_range(4) == 0) ? $urandom_range(KLEN, 5)
                                                    : $urandom_range(4, 1);
                    lenf = (n == KLEN && $urandom_range(1)) ? $urandom_range(63, KLEN) : n;
                    define_keyword(s, n, lenf, 8'h00, 1'b1);
                end else if (act < 15) begin
                    set_length(s, 0);
                end else if (act < 20) begin
                    load_byte(s, $urandom_range(KLEN - 1), 8'($urandom));
                end else if (act < 24) begin
                    // Random length, kept to the written prefix of the slot
                    lenf = $urandom_range(63);
                    eff  = (lenf > KLEN) ? KLEN : lenf;
                    ok   = 1'b1;
                    for (int p = 0; p < eff; p++)
                        if (!shadow_written[s][p]) ok = 1'b0;
                    set_length(s, ok ? lenf : 0);
                end else if (act < 27) begin
                    restart_stream();
                end else if (act < 45) begin
                    // Plant an active keyword in the stream
                    if (shadow_len[s] > 0) begin
                        for (int p = 0; p < shadow_len[s]; p++) scan_byte(shadow_bytes[s][p]);
                    end else begin
                        scan_byte(pick_byte());
                    end
                end else begin
                    scan_byte(pick_byte());
                end
                phase_count++;
            end
        end

        // Drain and let the block go quiet
        idle_on = 1'b1;
        settle();

        $display("Summary: %0d items, %0d hits checked under %0d start-address settings",
                 item_count, hits_seen, settings);
        $display("Covered loads, lengths, disables, restarts, address wrap and full-slot floods");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
sv/mkbm_pkg.sv
sv/mkbm_cell.sv
sv/mkbm_hit_seq.sv
sv/multi_keyword_byte_matcher.sv
dv/mkbm_hit_tracker.sv
dv/tb_multi_keyword_byte_matcher.sv
